// File: rtl/peer_keepalive_monitor_defines.svh
// Assertion macros for the peer keepalive monitor.
// Used by the modules under rtl; needs a clk and rst_n in scope.
`ifndef PEER_KEEPALIVE_MONITOR_DEFINES_SVH
`define PEER_KEEPALIVE_MONITOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PKM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PKM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PKM_ASSERT(label, prop, msg)
`define PKM_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// File: rtl/pkm_pkg.sv
// Shared types and constants of the peer keepalive monitor.
// No dependencies.
package pkm_pkg;

    localparam int PEERS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int STEP_W      = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [19:0] PERIODIC_RESET = 20'd60000;
    localparam logic [19:0] TRANSMIT_RESET = 20'd5000;
    localparam logic [7:0]  RETRY_RESET    = 8'd3;
    localparam logic [7:0]  RETRY_MAX      = 8'd255;

    localparam logic [1:0] CFG_PERIODIC = 2'd0;
    localparam logic [1:0] CFG_TRANSMIT = 2'd1;
    localparam logic [1:0] CFG_RETRY    = 2'd2;

    localparam logic [1:0] EV_ACK  = 2'd0;
    localparam logic [1:0] EV_SEND = 2'd1;
    localparam logic [1:0] EV_DOWN = 2'd2;
    localparam logic [1:0] EV_FULL = 2'd3;

    localparam logic [1:0] KIND_HEARTBEAT = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_RESP = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_TICK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] peer_address;
        logic [1:0]  interface_kind;
    } in_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] out_address;
        logic [1:0]  out_kind;
        logic [15:0] sequence_res;
        logic [7:0]  retries;
        logic        last;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [1:0]  kind;
        logic        awaiting;
        logic [19:0] countdown;
        logic [7:0]  retries;
    } entry_t;

endpackage

// File: rtl/pkm_cell.sv
// One peer table cell of the rotating ring.
// Depends on pkm_pkg.
module pkm_cell
    import pkm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  entry_t d,
    output entry_t q
);

    logic   valid_reg;
    entry_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

// File: rtl/peer_keepalive_monitor.sv
// Top level of the peer keepalive monitor: cell ring and pass sequencer.
// Depends on pkm_pkg, pkm_cell and peer_keepalive_monitor_defines.svh.

// The peer table is a ring of PEERS cells that rotates one cell per cycle
// during a scan, update or tick pass, unless a tick stalls on a full
// output; the sequencer edits the entry at the head. A tick takes one
// revolution and, when it produced results, then hands over its final
// result in the flush state. An add or a response searches for one
// revolution; when it has an entry to edit it updates in a second one and
// then flushes its result once the output is free; an unknown peer on a
// response or a full table on an add goes straight to the flush. One
// transaction is worked at a time; ready is high only when idle.
`include "peer_keepalive_monitor_defines.svh"
module peer_keepalive_monitor
    import pkm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [19:0] periodic_reg;
    logic [19:0] transmit_reg;
    logic [7:0]  retry_limit_reg;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [1:0]  kind_reg;
    logic found_reg, free_reg;
    logic [STEP_W-1:0] match_idx_reg, free_idx_reg;
    logic [15:0] seq_reg [4];

    logic pend_valid_reg;
    out_t pend_reg;
    logic out_valid_reg;
    out_t out_reg;

    entry_t cell_q [PEERS];
    entry_t head, head_next;
    logic   shift;
    logic   gen, gen_ok, stall;
    out_t   gen_item;
    logic   seq_wr;
    logic [15:0] seq_new;
    logic [1:0]  kidx;
    logic   last_step, match_now, out_free;
    logic [STEP_W-1:0] tgt;

    genvar g;
    generate
        for (g = 0; g < PEERS; g++)
        begin : g_cell
            entry_t d;
            if (g == PEERS - 1)
            begin : g_tail
                assign d = head_next;
            end
            else
            begin : g_mid
                assign d = cell_q[g + 1];
            end
            pkm_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (d),
                .q     (cell_q[g])
            );
        end
    endgenerate

    assign head      = cell_q[0];
    assign last_step = (step_reg == STEP_W'(PEERS - 1));
    assign match_now = head.valid && (head.address == addr_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign tgt       = found_reg ? match_idx_reg : free_idx_reg;
    assign kidx      = (state_reg == ST_APPLY && !found_reg) ? kind_reg : head.kind;

    // datapath on the head cell
    always_comb
    begin
        head_next = head;
        gen       = 1'b0;
        gen_item  = '0;
        seq_wr    = 1'b0;
        seq_new   = seq_reg[kidx] + 16'd1;
        shift     = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                shift = 1'b1;
            end
            ST_APPLY:
            begin
                shift = 1'b1;
                if (step_reg == tgt)
                begin
                    if (op_reg == OP_ADD && !found_reg)
                    begin
                        head_next.valid   = 1'b1;
                        head_next.address = addr_reg;
                        head_next.kind    = kind_reg;
                        head_next.retries = '0;
                    end
                    if (op_reg == OP_RESP)
                    begin
                        head_next.retries = '0;
                    end
                    head_next.awaiting  = 1'b0;
                    head_next.countdown = periodic_reg;
                    gen = 1'b1;
                    gen_item = '{EV_ACK, head_next.address, head_next.kind,
                                 seq_reg[kidx], head_next.retries, 1'b0};
                end
            end
            ST_TICK:
            begin
                if (head.valid)
                begin
                    if (head.countdown > 20'd1)
                    begin
                        head_next.countdown = head.countdown - 20'd1;
                    end
                    else if (res_count_reg >= CNT_W'(MAX_RESULTS))
                    begin
                        head_next.countdown = 20'd1;
                    end
                    else if (head.retries >= retry_limit_reg)
                    begin
                        gen = 1'b1;
                        head_next.valid = 1'b0;
                        gen_item = '{EV_DOWN, head.address, head.kind,
                                     seq_reg[kidx], head.retries, 1'b0};
                    end
                    else
                    begin
                        gen = 1'b1;
                        if (!head.awaiting)
                        begin
                            seq_wr = 1'b1;
                            head_next.awaiting = 1'b1;
                        end
                        else if (head.retries < RETRY_MAX)
                        begin
                            head_next.retries = head.retries + 8'd1;
                        end
                        head_next.countdown = transmit_reg;
                        gen_item = '{EV_SEND, head.address, head.kind,
                                     seq_wr ? seq_new : seq_reg[kidx],
                                     head_next.retries, 1'b0};
                    end
                end
                shift = 1'b1;
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase
        stall = (state_reg == ST_TICK) && gen && pend_valid_reg && !out_free;
        if (stall)
        begin
            shift  = 1'b0;
            seq_wr = 1'b0;
        end
        gen_ok = gen && !stall;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.op)
                        OP_ADD, OP_RESP: state_next = ST_SCAN;
                        OP_TICK:         state_next = ST_TICK;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (last_step)
                begin
                    if ((found_reg || match_now) ||
                        (op_reg == OP_ADD && (free_reg || !head.valid)))
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_APPLY:
            begin
                if (last_step)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_TICK:
            begin
                if (shift && last_step)
                begin
                    state_next = (pend_valid_reg || gen_ok) ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periodic_reg    <= PERIODIC_RESET;
            transmit_reg    <= TRANSMIT_RESET;
            retry_limit_reg <= RETRY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIODIC: periodic_reg    <= cfg_data;
                CFG_TRANSMIT: transmit_reg    <= cfg_data;
                CFG_RETRY:    retry_limit_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            res_count_reg  <= '0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            match_idx_reg  <= '0;
            free_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            seq_reg[0]     <= '0;
            seq_reg[1]     <= '0;
            seq_reg[2]     <= '0;
            seq_reg[KIND_HEARTBEAT] <= 16'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (seq_wr)
            begin
                seq_reg[kidx] <= seq_new;
            end
            if (state_reg == ST_IDLE)
            begin
                step_reg      <= '0;
                res_count_reg <= '0;
                found_reg     <= 1'b0;
                free_reg      <= 1'b0;
            end
            else if (shift)
            begin
                step_reg <= last_step ? '0 : step_reg + STEP_W'(1);
            end
            if (state_reg == ST_SCAN)
            begin
                if (match_now && !found_reg)
                begin
                    found_reg     <= 1'b1;
                    match_idx_reg <= step_reg;
                end
                if (!head.valid && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= step_reg;
                end
                if (last_step && state_next == ST_FLUSH)
                begin
                    pend_valid_reg <= 1'b1;
                    pend_reg <= '{(op_reg == OP_ADD) ? EV_FULL : EV_ACK,
                                  addr_reg, kind_reg, 16'd0, 8'd0, 1'b0};
                end
            end
            if (gen_ok)
            begin
                pend_valid_reg <= 1'b1;
                pend_reg       <= gen_item;
                res_count_reg  <= res_count_reg + CNT_W'(1);
            end
            if (state_reg == ST_FLUSH && out_free)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (gen_ok && pend_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= in_item.op;
            addr_reg <= in_item.peer_address;
            kind_reg <= in_item.interface_kind;
        end
        if (state_reg == ST_FLUSH && out_free)
        begin
            out_reg <= '{pend_reg.event_res, pend_reg.out_address, pend_reg.out_kind,
                         pend_reg.sequence_res, pend_reg.retries, 1'b1};
        end
        else if (gen_ok && pend_valid_reg)
        begin
            out_reg <= '{pend_reg.event_res, pend_reg.out_address, pend_reg.out_kind,
                         pend_reg.sequence_res, pend_reg.retries, 1'b0};
        end
    end

    `PKM_ASSERT(a_flush_has_result, (state_reg != ST_FLUSH) || pend_valid_reg, "flush without result")
    `PKM_ASSERT(a_idle_no_pending, (state_reg != ST_IDLE) || !pend_valid_reg, "result left pending")
    `PKM_ASSERT_NEXT(a_stall_holds_ring, stall, $stable(step_reg), "ring moved on a stall")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of peer_keepalive_monitor: random and directed peer traffic.
// Depends on pkm_pkg and the RTL under rtl; predicts results in a behavioral model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pkm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_item;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_PERIODIC;
    logic [19:0] cfg_data = '0;

    peer_keepalive_monitor dut (.*);

    always #5 clk = ~clk;

    // model state
    logic [19:0] m_periodic;
    logic [19:0] m_transmit;
    logic [7:0]  m_limit;
    entry_t      table_q [PEERS];
    logic [15:0] seq_by_kind [4];

    in_t  pending_items [$];
    out_t expected_results [$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off = 0;
    bit   hold_req = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic int lookup(input logic [31:0] a);
        for (int i = 0; i < PEERS; i++)
            if (table_q[i].valid && table_q[i].address == a)
                return i;
        return -1;
    endfunction

    function automatic out_t mk(input logic [1:0] ev, input logic [31:0] a,
                                input logic [1:0] k, input logic [15:0] s,
                                input logic [7:0] r);
        out_t o;
        o.event_res = ev;
        o.out_address = a;
        o.out_kind = k;
        o.sequence_res = s;
        o.retries = r;
        o.last = 1'b0;
        return o;
    endfunction

    task automatic predict_keepalive(input in_t it);
        int i;
        int n;
        logic [1:0] k;
        out_t res [$];
        out_t o;
        if (it.op == OP_ADD)
        begin
            i = lookup(it.peer_address);
            if (i < 0)
            begin
                for (i = 0; i < PEERS; i++)
                    if (!table_q[i].valid)
                        break;
                if (i >= PEERS)
                begin
                    o = mk(EV_FULL, it.peer_address, it.interface_kind, '0, '0);
                    o.last = 1'b1;
                    expected_results.push_back(o);
                    return;
                end
                table_q[i].valid = 1'b1;
                table_q[i].address = it.peer_address;
                table_q[i].kind = it.interface_kind;
                table_q[i].retries = '0;
            end
            table_q[i].awaiting = 1'b0;
            table_q[i].countdown = m_periodic;
            o = mk(EV_ACK, table_q[i].address, table_q[i].kind,
                   seq_by_kind[table_q[i].kind], table_q[i].retries);
            o.last = 1'b1;
            expected_results.push_back(o);
        end
        else if (it.op == OP_RESP)
        begin
            i = lookup(it.peer_address);
            if (i < 0)
                o = mk(EV_ACK, it.peer_address, it.interface_kind, '0, '0);
            else
            begin
                table_q[i].retries = '0;
                table_q[i].awaiting = 1'b0;
                table_q[i].countdown = m_periodic;
                o = mk(EV_ACK, table_q[i].address, table_q[i].kind,
                       seq_by_kind[table_q[i].kind], '0);
            end
            o.last = 1'b1;
            expected_results.push_back(o);
        end
        else if (it.op == OP_TICK)
        begin
            n = 0;
            for (i = 0; i < PEERS; i++)
            begin
                if (!table_q[i].valid)
                    continue;
                if (table_q[i].countdown > 1)
                begin
                    table_q[i].countdown--;
                    continue;
                end
                if (n >= MAX_RESULTS)
                begin
                    table_q[i].countdown = 20'd1;
                    continue;
                end
                k = table_q[i].kind;
                if (table_q[i].retries >= m_limit)
                begin
                    res.push_back(mk(EV_DOWN, table_q[i].address, k, seq_by_kind[k],
                                     table_q[i].retries));
                    n++;
                    table_q[i].valid = 1'b0;
                    continue;
                end
                if (!table_q[i].awaiting)
                begin
                    seq_by_kind[k] = seq_by_kind[k] + 16'd1;
                    table_q[i].awaiting = 1'b1;
                end
                else if (table_q[i].retries != RETRY_MAX)
                    table_q[i].retries++;
                table_q[i].countdown = m_transmit;
                res.push_back(mk(EV_SEND, table_q[i].address, k, seq_by_kind[k],
                                 table_q[i].retries));
                n++;
            end
            if (n > 0)
                res[n - 1].last = 1'b1;
            foreach (res[j])
                expected_results.push_back(res[j]);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predict_keepalive(in_item);
            void'(pending_items.pop_front());
        end
        if ((in_valid && !in_ready) || !rst_n)
        begin
        end
        else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            in_valid <= 1'b1;
            in_item <= pending_items[0];
        end
        else
            in_valid <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result %p", out_item));
            else
            begin
                out_t e;
                e = expected_results.pop_front();
                if (out_item.event_res != e.event_res)
                    report_mismatch($sformatf("event %0d want %0d", out_item.event_res,
                                              e.event_res));
                if (out_item.out_address != e.out_address)
                    report_mismatch($sformatf("address %h want %h", out_item.out_address,
                                              e.out_address));
                if (out_item.out_kind != e.out_kind)
                    report_mismatch($sformatf("kind %0d want %0d", out_item.out_kind,
                                              e.out_kind));
                if (out_item.sequence_res != e.sequence_res)
                    report_mismatch($sformatf("sequence %0d want %0d",
                                              out_item.sequence_res, e.sequence_res));
                if (out_item.retries != e.retries)
                    report_mismatch($sformatf("retries %0d want %0d", out_item.retries,
                                              e.retries));
                if (out_item.last != e.last)
                    report_mismatch($sformatf("last %0d want %0d", out_item.last, e.last));
            end
        end
        if (hold_req && hold_off == 0)
            hold_off <= 400;
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
        out_ready <= rst_n && hold_off <= 1 && !(hold_req && hold_off == 0)
                     && $urandom_range(99) >= recv_stall_pct;
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0
               || hold_off != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PERIODIC) m_periodic = val;
        else if (idx == CFG_TRANSMIT) m_transmit = val;
        else m_limit = val[7:0];
    endtask

    function automatic in_t item(input op_t op, input logic [31:0] a, input logic [1:0] k);
        in_t t;
        t.op = op;
        t.peer_address = a;
        t.interface_kind = k;
        return t;
    endfunction

    // peer addresses live in a small pool so adds, responses and expiries meet
    logic [31:0] pool [24];

    task automatic random_phase(input int count);
        int r;
        for (int j = 0; j < count; j++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                pending_items.push_back(item(OP_TICK, $urandom, 2'($urandom)));
            else if (r < 75)
                pending_items.push_back(item(OP_ADD, pool[$urandom_range(23)],
                                             2'($urandom)));
            else if (r < 93)
                pending_items.push_back(item(OP_RESP, pool[$urandom_range(23)],
                                             2'($urandom)));
            else if (r < 97)
                pending_items.push_back(item(OP_RESP, $urandom, 2'($urandom)));
            else
                pending_items.push_back(item(op_t'(2'd3), $urandom, 2'($urandom)));
        end
    endtask

    initial
    begin
        m_periodic = PERIODIC_RESET;
        m_transmit = TRANSMIT_RESET;
        m_limit = RETRY_RESET;
        foreach (table_q[i]) table_q[i] = '0;
        seq_by_kind[0] = 16'd0; seq_by_kind[1] = 16'd0; seq_by_kind[2] = 16'd0;
        seq_by_kind[KIND_HEARTBEAT] = 16'd1;
        foreach (pool[i]) pool[i] = $urandom;
        pool[0] = 32'h0; pool[1] = 32'hFFFF_FFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: defaults, unknown response, invalid op, adds, full table, ticks
        pending_items.push_back(item(OP_RESP, 32'hFFFF_FFFF, 2'd3));
        pending_items.push_back(item(OP_TICK, 32'h0, 2'd0));
        pending_items.push_back(item(op_t'(2'd3), 32'hA5A5_5A5A, 2'd1));
        wait_drained();
        write_reg(CFG_PERIODIC, 20'd0);
        write_reg(CFG_TRANSMIT, 20'd0);
        write_reg(CFG_RETRY, 20'd1);
        for (int j = 0; j < 17; j++)
            pending_items.push_back(item(OP_ADD, 32'h1000 + j, j[1:0]));
        pending_items.push_back(item(OP_ADD, 32'h1003, 2'd0));
        for (int j = 0; j < 4; j++)
            pending_items.push_back(item(OP_TICK, 32'h0, 2'd0));
        pending_items.push_back(item(OP_RESP, 32'h1005, 2'd2));
        wait_drained();
        write_reg(CFG_RETRY, 20'd0);
        pending_items.push_back(item(OP_TICK, 32'h0, 2'd0));
        pending_items.push_back(item(OP_TICK, 32'h0, 2'd0));
        wait_drained();

        // random phases across settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph % 4 == 1) ? 55 : (ph % 4 == 3) ? 12 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 55 : (ph % 4 == 3) ? 12 : 0;
            write_reg(CFG_PERIODIC, (ph == 5) ? 20'hFFFFF : 20'($urandom_range(1, 6)));
            write_reg(CFG_TRANSMIT, (ph == 4) ? 20'hFFFFF : 20'($urandom_range(1, 4)));
            write_reg(CFG_RETRY, (ph == 3) ? 20'd255 : 20'($urandom_range(0, 3)));
            if (ph == 2)
                hold_req = 1;
            random_phase(45);
            @(posedge clk);
            hold_req = 0;
            wait_drained();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
